/* rtl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define XBS_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("assertion failed");
`define XBS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define XBS_ASSERT(label, clk, rst_n, expr)
`define XBS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/xbs_pkg.sv */
package xbs_pkg;
	localparam int BLOCK_BYTES = 128;
	localparam int IDX_W = $clog2(BLOCK_BYTES);

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_CREQ = 8'h43;
	localparam logic [7:0] B_PAD = 8'h1a;
	localparam logic [7:0] B_FF = 8'hff;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [1:0] REG_MAX_RETRIES = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_CANCEL_ON_FAIL = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_REMOTE_CAN = 3'd1;
	localparam logic [2:0] ERR_LOCAL_CAN = 3'd2;
	localparam logic [2:0] ERR_BLOCK = 3'd3;
	localparam logic [2:0] ERR_EOT = 3'd4;
	localparam logic [2:0] ERR_NO_START = 3'd5;
	localparam logic [2:0] ERR_READ = 3'd6;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WAIT_RX = 3'd1,
		MODE_LOADING = 3'd2,
		MODE_WAIT_ACK = 3'd3,
		MODE_WAIT_EOT = 3'd4,
		MODE_DONE = 3'd5,
		MODE_FAILED = 3'd6,
		MODE_CANCELLED = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_RX = 3'd1,
		OP_TICK = 3'd2,
		OP_PAYLOAD = 3'd3,
		OP_EOF = 3'd4,
		OP_SRC_ERR = 3'd5,
		OP_PULL = 3'd6,
		OP_CANCEL = 3'd7
	} op_t;

	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_byte;
		logic tx_last;
		logic need_payload;
		logic [2:0] status;
		logic [2:0] error_code;
		logic [15:0] retries_total;
		logic [31:0] bytes_acked;
		logic rx_ignored;
	} res_t;

	function automatic logic [15:0] crc16_byte(logic [15:0] acc, logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction
endpackage

/* rtl/xbs_ram.sv */
module xbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/xbs_core.sv */
`include "assert_macros.svh"
module xbs_core import xbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [19:0] cfg_data,
	input logic go,
	input logic [2:0] op,
	input logic [7:0] data_byte,
	input logic chunk_last,
	output res_t res
);
	logic [7:0] max_retries_q;
	logic [19:0] timeout_q;
	logic cof_q;

	mode_t mode_q, n_mode;
	logic [7:0] plen_q, n_plen, bnum_q, n_bnum, att_q, n_att;
	logic [15:0] rtot_q, n_rtot, acc_q, n_acc;
	logic [31:0] acked_q, n_acked;
	logic cseen_q, n_cseen, crc_q, n_crc, lag_q, n_lag;
	logic [19:0] el_q, n_el;
	logic [7:0] emit_q, n_emit, copies_q, n_copies, eot_q, n_eot;
	logic [1:0] can_q, n_can;
	logic [2:0] fault_q, n_fault;

	logic we;
	logic [IDX_W-1:0] raddr;
	logic [7:0] rdata;

	logic active, need;
	logic [32:0] sum;
	logic [19:0] el_inc;
	logic [7:0] pkt_len, num, idx, b, emit_inc;
	logic txv, ign;
	logic [7:0] txb;

	xbs_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(plen_q[IDX_W-1:0]), .wdata(data_byte),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q <= 8'd10;
			timeout_q <= 20'd10000;
			cof_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_RETRIES: max_retries_q <= cfg_data[7:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_CANCEL_ON_FAIL: cof_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_mode = mode_q; n_plen = plen_q; n_bnum = bnum_q; n_att = att_q;
		n_rtot = rtot_q; n_acc = acc_q; n_acked = acked_q; n_cseen = cseen_q;
		n_crc = crc_q; n_lag = lag_q; n_el = el_q; n_emit = emit_q;
		n_copies = copies_q; n_eot = eot_q; n_can = can_q; n_fault = fault_q;
		we = 1'b0; txv = 1'b0; txb = 8'h00; ign = 1'b0;
		active = (mode_q == MODE_WAIT_RX) || (mode_q == MODE_LOADING)
			|| (mode_q == MODE_WAIT_ACK) || (mode_q == MODE_WAIT_EOT);
		need = (mode_q == MODE_LOADING) && (copies_q == 8'd0);
		sum = {1'b0, acked_q} + {25'd0, plen_q};
		el_inc = (el_q != 20'hfffff) ? el_q + 20'd1 : el_q;
		pkt_len = crc_q ? 8'd133 : 8'd132;
		num = bnum_q - {7'd0, lag_q};
		idx = emit_q - 8'd3;
		b = (idx < plen_q) ? rdata : B_PAD;
		emit_inc = emit_q + 8'd1;
		if (go) begin
			case (op_t'(op))
				OP_START: begin
					n_mode = MODE_WAIT_RX; n_plen = '0; n_bnum = 8'd1; n_att = '0;
					n_rtot = '0; n_acc = '0; n_acked = '0; n_el = '0;
					n_cseen = 1'b0; n_crc = 1'b0; n_lag = 1'b0; n_emit = '0;
					n_copies = '0; n_eot = '0; n_can = '0; n_fault = ERR_NONE;
				end
				OP_RX: begin
					if (!active) begin
						ign = 1'b1;
					end else if (data_byte == B_CAN) begin
						if (cseen_q) begin
							n_mode = MODE_CANCELLED; n_fault = ERR_REMOTE_CAN;
						end
						n_cseen = 1'b1;
					end else begin
						n_cseen = 1'b0;
						case (mode_q)
							MODE_WAIT_RX: begin
								if (data_byte == B_CREQ || data_byte == B_NAK) begin
									n_crc = (data_byte == B_CREQ);
									n_att = '0;
									n_mode = MODE_LOADING;
									if (copies_q == 8'd0)
										n_plen = '0;
								end
							end
							MODE_WAIT_ACK: begin
								if (data_byte == B_ACK) begin
									n_acked = sum[32] ? 32'hffffffff : sum[31:0];
									n_copies = (emit_q != 8'd0) ? 8'd1 : 8'd0;
									n_lag = (emit_q != 8'd0) ? 1'b1 : lag_q;
									n_bnum = bnum_q + 8'd1;
									n_att = '0;
									n_mode = MODE_LOADING;
									if (emit_q == 8'd0)
										n_plen = '0;
								end else if (data_byte == B_NAK) begin
									if (att_q >= max_retries_q) begin
										if (cof_q) n_can = 2'd2;
										n_mode = MODE_FAILED; n_fault = ERR_BLOCK;
									end else begin
										n_att = att_q + 8'd1;
										if (rtot_q != 16'hffff) n_rtot = rtot_q + 16'd1;
										if (copies_q != 8'hff) n_copies = copies_q + 8'd1;
										n_el = '0;
									end
								end
							end
							MODE_WAIT_EOT: begin
								if (data_byte == B_ACK) begin
									n_mode = MODE_DONE;
								end else if (data_byte == B_NAK) begin
									if (att_q >= max_retries_q) begin
										if (cof_q) n_can = 2'd2;
										n_mode = MODE_FAILED; n_fault = ERR_EOT;
									end else begin
										n_att = att_q + 8'd1;
										if (rtot_q != 16'hffff) n_rtot = rtot_q + 16'd1;
										if (eot_q != 8'hff) n_eot = eot_q + 8'd1;
										n_el = '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				OP_TICK: begin
					if (mode_q == MODE_WAIT_RX || mode_q == MODE_WAIT_ACK
							|| mode_q == MODE_WAIT_EOT) begin
						if (el_inc < timeout_q) begin
							n_el = el_inc;
						end else begin
							n_el = '0;
							if (att_q >= max_retries_q) begin
								if (cof_q) n_can = 2'd2;
								n_mode = MODE_FAILED;
								n_fault = (mode_q == MODE_WAIT_RX) ? ERR_NO_START :
									(mode_q == MODE_WAIT_ACK) ? ERR_BLOCK : ERR_EOT;
							end else begin
								n_att = att_q + 8'd1;
								if (rtot_q != 16'hffff) n_rtot = rtot_q + 16'd1;
								if (mode_q == MODE_WAIT_ACK && copies_q != 8'hff)
									n_copies = copies_q + 8'd1;
								if (mode_q == MODE_WAIT_EOT && eot_q != 8'hff)
									n_eot = eot_q + 8'd1;
							end
						end
					end
				end
				OP_PAYLOAD: begin
					if (need) begin
						we = (plen_q < 8'(BLOCK_BYTES));
						n_plen = plen_q + 8'd1;
						if (chunk_last || n_plen >= 8'(BLOCK_BYTES)) begin
							n_copies = 8'd1; n_mode = MODE_WAIT_ACK; n_el = '0;
						end
					end
				end
				OP_EOF: begin
					if (need) begin
						if (plen_q == 8'd0) begin
							n_att = '0;
							if (eot_q != 8'hff) n_eot = eot_q + 8'd1;
							n_mode = MODE_WAIT_EOT;
						end else begin
							n_copies = 8'd1; n_mode = MODE_WAIT_ACK;
						end
						n_el = '0;
					end
				end
				OP_SRC_ERR: begin
					if (mode_q == MODE_LOADING) begin
						if (cof_q) n_can = 2'd2;
						n_mode = MODE_FAILED; n_fault = ERR_READ;
					end
				end
				OP_PULL: begin
					if (copies_q != 8'd0) begin
						txv = 1'b1;
						if (emit_q == 8'd0)
							txb = B_SOH;
						else if (emit_q == 8'd1)
							txb = num;
						else if (emit_q == 8'd2)
							txb = B_FF - num;
						else if (emit_q < 8'(3 + BLOCK_BYTES)) begin
							txb = b;
							if (crc_q)
								n_acc = crc16_byte((idx == 8'd0) ? 16'd0 : acc_q, b);
							else
								n_acc = {8'd0, ((idx == 8'd0) ? 8'd0 : acc_q[7:0]) + b};
						end else if (emit_q == 8'(3 + BLOCK_BYTES) && crc_q)
							txb = acc_q[15:8];
						else
							txb = acc_q[7:0];
						n_emit = emit_inc;
						if (emit_inc >= pkt_len) begin
							n_emit = '0;
							n_copies = copies_q - 8'd1;
							n_lag = 1'b0;
							if (mode_q == MODE_LOADING && n_copies == 8'd0)
								n_plen = '0;
						end
					end else if (eot_q != 8'd0) begin
						txv = 1'b1; txb = B_EOT; n_eot = eot_q - 8'd1;
					end else if (can_q != 2'd0) begin
						txv = 1'b1; txb = B_CAN; n_can = can_q - 2'd1;
					end
				end
				OP_CANCEL: begin
					if (active) begin
						n_can = 2'd2; n_mode = MODE_CANCELLED; n_fault = ERR_LOCAL_CAN;
					end
				end
				default: ;
			endcase
		end
		raddr = IDX_W'(n_emit - 8'd3);
		res.tx_valid = txv;
		res.tx_byte = txb;
		res.tx_last = txv && n_copies == 8'd0 && n_eot == 8'd0 && n_can == 2'd0;
		res.need_payload = (n_mode == MODE_LOADING) && (n_copies == 8'd0);
		res.status = n_mode;
		res.error_code = n_fault;
		res.retries_total = n_rtot;
		res.bytes_acked = n_acked;
		res.rx_ignored = ign;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE; plen_q <= '0; bnum_q <= 8'd1; att_q <= '0;
			rtot_q <= '0; acc_q <= '0; acked_q <= '0; cseen_q <= 1'b0;
			crc_q <= 1'b0; lag_q <= 1'b0; el_q <= '0; emit_q <= '0;
			copies_q <= '0; eot_q <= '0; can_q <= '0; fault_q <= ERR_NONE;
		end else begin
			mode_q <= n_mode; plen_q <= n_plen; bnum_q <= n_bnum; att_q <= n_att;
			rtot_q <= n_rtot; acc_q <= n_acc; acked_q <= n_acked; cseen_q <= n_cseen;
			crc_q <= n_crc; lag_q <= n_lag; el_q <= n_el; emit_q <= n_emit;
			copies_q <= n_copies; eot_q <= n_eot; can_q <= n_can; fault_q <= n_fault;
		end
	end

	`XBS_ASSERT(a_emit_range, clk, arst_n, emit_q < 8'd133)
	`XBS_ASSERT(a_lag_one_copy, clk, arst_n, !lag_q || copies_q == 8'd1)
	`XBS_ASSERT(a_load_bound, clk, arst_n, plen_q <= 8'(BLOCK_BYTES))
endmodule

/* rtl/xmodem_block_sender.sv */
// an accepted word is held in the input register, and its result is then held in the result register
// throughput: one word per cycle while out_stall does not hold the output, every operation including a pull
// the packet store is a 128-byte ram read one byte ahead of the pull position
// reset: asynchronous, active low; idle, counters clear, block number one, registers at defaults
`include "assert_macros.svh"
module xmodem_block_sender import xbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [19:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] op,
	input logic [7:0] data_byte,
	input logic chunk_last,
	output logic out_valid,
	input logic out_stall,
	output logic tx_valid,
	output logic [7:0] tx_byte,
	output logic tx_last,
	output logic need_payload,
	output logic [2:0] status,
	output logic [2:0] error_code,
	output logic [15:0] retries_total,
	output logic [31:0] bytes_acked,
	output logic rx_ignored
);
	logic valid_s1, adv, go;
	logic [2:0] op_s1;
	logic [7:0] data_s1;
	logic last_s1;
	res_t res, res_s2;

	assign adv = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign go = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv)
				out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			data_s1 <= data_byte;
			last_s1 <= chunk_last;
		end
		if (go)
			res_s2 <= res;
	end

	xbs_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .go(go), .op(op_s1), .data_byte(data_s1),
		.chunk_last(last_s1), .res(res)
	);

	assign tx_valid = res_s2.tx_valid;
	assign tx_byte = res_s2.tx_byte;
	assign tx_last = res_s2.tx_last;
	assign need_payload = res_s2.need_payload;
	assign status = res_s2.status;
	assign error_code = res_s2.error_code;
	assign retries_total = res_s2.retries_total;
	assign bytes_acked = res_s2.bytes_acked;
	assign rx_ignored = res_s2.rx_ignored;

	`XBS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1)
	`XBS_ASSERT(a_last_valid, clk, arst_n, !out_valid || !tx_last || tx_valid)
	`XBS_ASSERT_NEXT(a_out_hold, clk, arst_n, go, out_valid)
endmodule
